FILE: rtl/piqu_pkg.sv
// Shared types and constants for the positional insert/remove queue.
package piqu_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OPC_W = 3;
	localparam int DATA_W = 32;
	localparam int POS_W = 5;
	localparam int ECNT_W = 5;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OPC_W-1:0] {
		OP_ENQ    = 3'd0,
		OP_DEQ    = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_STATUS = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// What a storage cell loads at the next edge.
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LEFT  = 2'd1,
		SEL_RIGHT = 2'd2,
		SEL_LOAD  = 2'd3
	} cell_sel_t;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] head_value;
		logic [ECNT_W-1:0]        element_count;
		logic                     is_empty;
		logic [1:0]               status;
	} rsp_t;

endpackage

FILE: rtl/piqu_cell.sv
// One storage cell of the queue: holds one element and takes from either neighbour or loads a new value.
module piqu_cell
	import piqu_pkg::*;
(
	input  logic                     clk,
	input  cell_sel_t                sel,
	input  logic signed [DATA_W-1:0] left_q,
	input  logic signed [DATA_W-1:0] right_q,
	input  logic signed [DATA_W-1:0] load_value,
	output logic signed [DATA_W-1:0] q
);

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			SEL_HOLD:  data_q <= data_q;
			SEL_LEFT:  data_q <= left_q;
			SEL_RIGHT: data_q <= right_q;
			SEL_LOAD:  data_q <= load_value;
			default:   data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

FILE: rtl/positional_insert_remove_queue_unit.sv
// Top level of the positional insert/remove queue: control and a row of storage cells.
//
// Usage: an operation enters on the req channel (valid/ready) as opcode, value and
// position; enqueue, dequeue, insert at a position, remove at a position or status
// only. Each transaction gives exactly one transaction on the rsp channel carrying the
// head element, the element count, an empty flag and a status code.
// Elements sit in a row of cells, head in cell 0. Insert loads the value at the
// position and shifts every cell beyond it by one place; remove shifts every cell at
// or beyond the position by one place, all in the same cycle from a neighbour.
// The response is registered and appears in the cycle after the request is taken.
// Throughput is one operation per cycle for as long as rsp_ready is high. When the
// receiver stalls, the response register holds its transaction and req_ready falls
// until it is taken; a new request is taken in the same cycle that the waiting
// response leaves.
// A rejected operation (empty, out of range or full) leaves the queue unchanged and
// only reports its status.
// Reset empties the queue at once; cell contents are not cleared and are never shown.
module positional_insert_remove_queue_unit
	import piqu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	logic                     accept;
	logic                     do_ins;
	logic                     do_rem;
	logic [CMP_W-1:0]         at;
	logic [CMP_W-1:0]         cnt_ext;
	logic [CMP_W-1:0]         pos_ext;
	status_t                  st;
	logic [CNT_W-1:0]         count_next;
	logic signed [DATA_W-1:0] head_next;
	logic signed [DATA_W-1:0] cell_q [DEPTH];
	cell_sel_t                cell_sel [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign cnt_ext   = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(req.position);

	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		at     = '0;
		st     = ST_OK;
		unique case (req.opcode)
			OP_ENQ: begin
				if (count_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
					at     = cnt_ext;
				end
			end
			OP_DEQ: begin
				if (count_q == '0) begin
					st = ST_EMPTY;
				end else begin
					do_rem = 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					st = ST_RANGE;
				end else if (count_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
					at     = pos_ext;
				end
			end
			OP_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					st = ST_RANGE;
				end else begin
					do_rem = 1'b1;
					at     = pos_ext;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_sel[i] = SEL_HOLD;
			if (accept && do_ins) begin
				if (CMP_W'(i) == at) begin
					cell_sel[i] = SEL_LOAD;
				end else if (CMP_W'(i) > at) begin
					cell_sel[i] = SEL_LEFT;
				end
			end else if (accept && do_rem) begin
				if (CMP_W'(i) >= at) begin
					cell_sel[i] = SEL_RIGHT;
				end
			end
		end
	end

	// The outermost cells have no neighbour on one side and take their own value there;
	// the last cell does so on a removal, when it falls beyond the count anyway.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		piqu_cell u_cell (
			.clk        (clk),
			.sel        (cell_sel[g]),
			.left_q     ((g == 0) ? cell_q[g] : cell_q[(g == 0) ? 0 : g - 1]),
			.right_q    ((g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1]),
			.load_value (req.value),
			.q          (cell_q[g])
		);
	end

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		priority if (count_next == '0) begin
			head_next = '0;
		end else if (do_ins && at == '0) begin
			head_next = req.value;
		end else if (do_rem && at == '0) begin
			head_next = cell_q[1];
		end else begin
			head_next = cell_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.head_value    <= head_next;
			rsp_q.element_count <= ECNT_W'(count_next);
			rsp_q.is_empty      <= (count_next == '0);
			rsp_q.status        <= st;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count exceeds capacity");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp_valid && rsp.element_count == ECNT_W'(count_q)))
		else $error("reported count differs from held count");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_empty) |-> (rsp.head_value == '0 && rsp.element_count == '0))
		else $error("empty response with non-zero head or count");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st != ST_OK) |=> $stable(count_q))
		else $error("rejected operation changed the queue");

endmodule
